@@ rtl/fpr_pkg.sv @@
`default_nettype none

package fpr_pkg;

   // Defaults for the top-level parameters
   localparam int FRAMES_DEF    = 8;
   localparam int PAGE_BITS_DEF = 16;

   // Fixed field widths
   localparam int PAGE_W = 16;   // page field on the request channel
   localparam int CFG_W  = 4;    // frames_in_use register
   localparam int SLOT_W = 3;    // slot field of the response
   localparam int CNT_W  = 32;   // hit and fault counters

   // Request and response bus widths (packed fields, padded to bytes)
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 72;

   // Reset value of frames_in_use
   localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;     // capture request, run the frame compare
      logic commit;   // apply replacement, update counters, load response
   } fpr_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic rsp_free; // response register empty or being drained this cycle
   } fpr_sts_type;

endpackage

`default_nettype wire

@@ rtl/fpr_ctrl.sv @@
`default_nettype none

module fpr_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire fpr_pkg::fpr_sts_type sts,
   output fpr_pkg::fpr_cmd_type     cmd
);
   import fpr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // wait here while the previous response is still held
            if (sts.rsp_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/fpr_dp.sv @@
`default_nettype none

module fpr_dp #(
   parameter int FRAMES    = fpr_pkg::FRAMES_DEF,
   parameter int PAGE_BITS = fpr_pkg::PAGE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [fpr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                          csr_we,
   input  wire logic [fpr_pkg::CFG_W-1:0]      csr_wdata,
   input  wire fpr_pkg::fpr_cmd_type          cmd,
   output fpr_pkg::fpr_sts_type               sts,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [fpr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                               rsp_tuser
);
   import fpr_pkg::*;

   localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int N_W    = $clog2(FRAMES + 1);
   localparam int CMP_W  = (N_W > CFG_W) ? N_W : CFG_W;
   localparam int PAD_W  = RSP_DATA_W - SLOT_W - 2 * CNT_W;

   // Frame storage
   logic [PAGE_BITS-1:0] frame_page_ff [FRAMES];
   logic [FRAMES-1:0]    frame_valid_ff;
   logic [FIDX_W-1:0]    ptr_ff;
   logic [CNT_W-1:0]     hits_ff;
   logic [CNT_W-1:0]     faults_ff;
   logic [CFG_W-1:0]     frames_cfg_ff;

   // Per-request registers
   logic [PAGE_BITS-1:0] page_ff;
   logic                 hit_ff;
   logic [FIDX_W-1:0]    slot_ff;

   // Response register
   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;

   logic [PAGE_BITS+PAGE_W-1:0] page_wide;
   logic [PAGE_BITS-1:0]        page_in;
   logic [CMP_W-1:0]            cfg_ext;
   logic [CMP_W-1:0]            n_act;
   logic [FRAMES-1:0]           match;
   logic                        hit_in;
   logic [FIDX_W-1:0]           slot_in;
   logic [FIDX_W-1:0]           victim;
   logic [FIDX_W-1:0]           ptr_in;
   logic [FIDX_W+SLOT_W-1:0]    fin_wide;
   logic [FIDX_W-1:0]           fin_slot;

   // Page masked to PAGE_BITS
   assign page_wide = (PAGE_BITS + PAGE_W)'(req_tdata[PAGE_W-1:0]);
   assign page_in   = page_wide[PAGE_BITS-1:0];

   // Active frame count, clamped to 1..FRAMES
   assign cfg_ext = CMP_W'(frames_cfg_ff);
   always_comb begin
      if (frames_cfg_ff == '0) begin
         n_act = CMP_W'(1);
      end else if (cfg_ext > CMP_W'(FRAMES)) begin
         n_act = CMP_W'(FRAMES);
      end else begin
         n_act = cfg_ext;
      end
   end

   // Parallel compare against all active, valid frames
   always_comb begin
      for (int j = 0; j < FRAMES; j++) begin
         match[j] = frame_valid_ff[j] && (frame_page_ff[j] == page_in) &&
                    (CMP_W'(j) < n_act);
      end
   end

   // Lowest matching slot
   always_comb begin
      slot_in = '0;
      for (int j = FRAMES - 1; j >= 0; j--) begin
         if (match[j]) begin
            slot_in = FIDX_W'(j);
         end
      end
   end
   assign hit_in = |match;

   // Replacement victim and next pointer
   assign victim = (CMP_W'(ptr_ff) < n_act) ? ptr_ff : '0;
   assign ptr_in = ((CMP_W'(victim) + CMP_W'(1)) == n_act) ? '0 : victim + FIDX_W'(1);
   assign fin_slot = hit_ff ? slot_ff : victim;
   assign fin_wide = (FIDX_W + SLOT_W)'(fin_slot);

   assign sts.rsp_free = !rsp_valid_ff || rsp_tready;

   // Config register
   always_ff @(posedge clock) begin
      if (reset) begin
         frames_cfg_ff <= CFG_RESET;
      end else if (csr_we) begin
         frames_cfg_ff <= csr_wdata;
      end
   end

   // Capture request and compare result
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         page_ff <= page_in;
         hit_ff  <= hit_in;
         slot_ff <= slot_in;
      end
   end

   // Frame pages (no reset; guarded by valid bits)
   always_ff @(posedge clock) begin
      if (cmd.commit && !hit_ff) begin
         frame_page_ff[victim] <= page_ff;
      end
   end

   // Valid bits, pointer and saturating counters
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= '0;
         ptr_ff         <= '0;
         hits_ff        <= '0;
         faults_ff      <= '0;
      end else if (cmd.commit) begin
         if (hit_ff) begin
            if (hits_ff != '1) begin
               hits_ff <= hits_ff + CNT_W'(1);
            end
         end else begin
            frame_valid_ff[victim] <= 1'b1;
            ptr_ff                 <= ptr_in;
            if (faults_ff != '1) begin
               faults_ff <= faults_ff + CNT_W'(1);
            end
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_hit_ff  <= hit_ff;
         rsp_slot_ff <= fin_wide[SLOT_W-1:0];
      end
   end

   // Counters only move on commit, so they stay in step with the response
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {PAD_W'(0), faults_ff, hits_ff, rsp_slot_ff};

endmodule

`default_nettype wire

@@ rtl/fifo_page_replacement_top.sv @@
// FIFO page replacement unit.
// Request channel (req_*): one page number per request in req_tdata[15:0].
// The page is checked against the active frames; a hit reports the lowest
// matching slot, a miss writes the page into the slot under a round-robin
// pointer that wraps at the active frame count.
// Response channel (rsp_*): one response per request. rsp_tuser is the hit
// flag; rsp_tdata carries slot, running hit count and running fault count.
// csr_we/csr_wdata write frames_in_use (0 acts as 1, above FRAMES as FRAMES).
// Each request passes through the controller states idle and update. Idle
// accepts the request and runs the parallel frame compare; update writes the
// victim frame and pointer on a miss, updates counters and loads the response
// register. The next request is taken the cycle after the update.
// Stall: a response waits in its register while rsp_tready is low; the next
// request is still accepted and compared, and holds in its update cycle
// until the waiting response is taken.
// Reset: synchronous, active high; all frames empty, pointer and counts zero,
// frames_in_use set to 8, no response pending.
`default_nettype none

module fifo_page_replacement_top #(
   parameter int FRAMES    = fpr_pkg::FRAMES_DEF,
   parameter int PAGE_BITS = fpr_pkg::PAGE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [fpr_pkg::REQ_DATA_W-1:0] req_tdata,  // [15:0] page
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [2:0] slot, [34:3] hit_count, [66:35] fault_count, [71:67] zero
   output logic [fpr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                               rsp_tuser,  // [0] hit
   input  wire logic                          csr_we,
   input  wire logic [fpr_pkg::CFG_W-1:0]      csr_wdata
);
   import fpr_pkg::*;

   fpr_cmd_type cmd;
   fpr_sts_type sts;

   fpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   fpr_dp #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

@@ rtl/fpr_checker.sv @@
`default_nettype none

module fpr_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [fpr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                          rsp_tuser
);
   import fpr_pkg::*;

   // One request at a time: no request accepted right after another
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted in back-to-back cycles");

   // A stalled response holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled response changed");

   // A hit response counts at least one hit
   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[SLOT_W+CNT_W-1:SLOT_W] != '0))
      else $error("hit reported with zero hit count");

   // A fault response counts at least one fault
   a_fault_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[SLOT_W+2*CNT_W-1:SLOT_W+CNT_W] != '0))
      else $error("fault reported with zero fault count");

   // Nothing pending in the first cycle after reset is released
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind fifo_page_replacement_top fpr_checker u_fpr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
